/* sv/tdsd_pkg.sv */
// tdsd_pkg: shared types, constants and encode helpers for the two-digit
// segment scan driver. No dependencies.
`default_nettype none

package tdsd_pkg;

   localparam int unsigned CFG_W     = 10;
   localparam int unsigned VALUE_W   = 8;
   localparam int unsigned SEG_W     = 3;
   localparam int unsigned PATTERN_W = 16;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   typedef enum logic [1:0] {
      CSR_SEGMENT_DWELL = 2'd0,
      CSR_DIGIT_GAP     = 2'd1,
      CSR_FRAME_GAP     = 2'd2,
      CSR_IDLE_POLL     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEG  = 2'd1,
      PH_DGAP = 2'd2,
      PH_FGAP = 2'd3
   } phase_type;

   localparam logic [CFG_W-1:0] DWELL_RESET       = 10'd10;
   localparam logic [CFG_W-1:0] DIGIT_GAP_RESET   = 10'd5;
   localparam logic [CFG_W-1:0] FRAME_GAP_RESET   = 10'd10;
   localparam logic [CFG_W-1:0] IDLE_POLL_RESET   = 10'd100;
   localparam logic [CFG_W-1:0] WAIT_ONE          = 10'd1;

   localparam logic [VALUE_W-1:0] VALUE_LIMIT = 8'd100;
   localparam logic [7:0]         DASH_PATTERN = 8'h40;
   localparam logic [7:0]         DOT_BIT      = 8'h80;

   // x / 10 == (x * 205) >> 11 for x below 1029
   localparam logic [7:0] RECIP_TEN   = 8'd205;
   localparam int unsigned RECIP_SHIFT = 11;
   localparam logic [7:0] TEN         = 8'd10;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic             found;
      logic [SEG_W-1:0] seg;
   } search_type;

   function automatic logic [7:0] digit_pattern(input logic [3:0] d);
      logic [7:0] p;
      case (d)
         4'd0:    p = 8'h3F;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h67;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // low byte = left digit, high byte = right digit
   function automatic logic [PATTERN_W-1:0] encode(input logic [VALUE_W-1:0] value,
                                                   input logic dot);
      logic [15:0] prod;
      logic [3:0]  tens;
      logic [7:0]  units;
      logic [7:0]  left;
      logic [7:0]  right;
      prod  = 16'(value) * 16'(RECIP_TEN);
      tens  = prod[RECIP_SHIFT +: 4];
      units = value - 8'(tens * TEN);
      if (value < VALUE_LIMIT) begin
         left  = digit_pattern(tens);
         right = digit_pattern(units[3:0]);
      end else begin
         left  = DASH_PATTERN;
         right = DASH_PATTERN;
      end
      if (dot) begin
         right = right | DOT_BIT;
      end
      return {right, left};
   endfunction

   // first lit segment at or above from
   function automatic search_type search(input logic [7:0] pat, input logic [3:0] from);
      search_type r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (pat[i] && (4'(i) >= from)) begin
            r.found = 1'b1;
            r.seg   = SEG_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/tdsd_update_queue.sv */
// tdsd_update_queue: circular queue of pending display pattern pairs.
// Depends on tdsd_pkg.
`default_nettype none

module tdsd_update_queue #(
   parameter int unsigned DEPTH = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire logic [tdsd_pkg::PATTERN_W-1:0]     push_data,
   input  wire logic                               pop,
   output logic      [tdsd_pkg::PATTERN_W-1:0]     head_data,
   output tdsd_pkg::queue_status_type              status
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);

   logic [tdsd_pkg::PATTERN_W-1:0] store_ff [DEPTH];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W:0]   tail_sum;
   logic [CNT_W:0]   tail_wrap;
   logic [IDX_W-1:0] tail_idx;
   logic             push_ok, pop_ok;

   assign status.full      = (count_ff == FULL_CNT);
   assign status.not_empty = (count_ff != '0);

   assign push_ok = push && !status.full;
   assign pop_ok  = pop && status.not_empty;

   assign tail_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign tail_wrap = (tail_sum >= DEPTH_SUM) ? (tail_sum - DEPTH_SUM) : tail_sum;
   assign tail_idx  = tail_wrap[IDX_W-1:0];

   assign head_data = store_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop_ok) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_ff[tail_idx] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/two_digit_segment_scan_driver_core.sv */
// two_digit_segment_scan_driver_core: top level of the two-digit scan driver.
// Depends on tdsd_pkg and tdsd_update_queue.
//
// Usage:
//   req channel carries one word per item: req_operation selects a 1 ms tick
//   (scan step) or a value update (req_value 0..255, req_dot). Values of 100
//   or more show a dash on both digits; req_dot lights segment H on the right.
//   Updates are queued (QUEUE_DEPTH entries); a full queue drops the update
//   and the matching rsp word has rsp_update_dropped set.
//   rsp channel returns exactly one word per req word, in order: the mux
//   address, digit select and showing flag as they stand after that item.
//   rsp_valid rises once the word has passed the input register and then,
//   through the scan and queue update, the output register.
//   Throughput is one word per cycle while rsp_ready is high; the input
//   register takes a new word in the same cycle the output register
//   hands its word over. When rsp_ready is low the output word holds,
//   the input register fills, and req_ready drops until the output is taken.
//   Reset empties the queue, clears the display and starts the idle poll
//   with a 100 tick wait; csr registers return to dwell 10, digit gap 5,
//   frame gap 10, idle poll 100.
//   csr writes take effect from the next wait that is loaded.
`default_nettype none

module two_digit_segment_scan_driver_core #(
   parameter int unsigned QUEUE_DEPTH = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_operation,
   input  wire logic [tdsd_pkg::VALUE_W-1:0]      req_value,
   input  wire logic                              req_dot,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [tdsd_pkg::SEG_W-1:0]        rsp_mux_address,
   output logic                                   rsp_digit_select,
   output logic                                   rsp_showing,
   output logic                                   rsp_update_dropped,

   input  wire logic                              csr_write_enable,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [tdsd_pkg::CFG_W-1:0]        csr_wdata
);

   // configuration
   logic [tdsd_pkg::CFG_W-1:0] dwell_ff, digit_gap_ff, frame_gap_ff, idle_poll_ff;
   logic [tdsd_pkg::CFG_W-1:0] dwell_eff, idle_eff;

   // input register
   logic                           in_valid_ff;
   logic                           in_op_ff;
   logic [tdsd_pkg::VALUE_W-1:0]   in_value_ff;
   logic                           in_dot_ff;

   // scan state
   tdsd_pkg::phase_type            phase_ff, phase_in;
   logic                           digit_ff, digit_in;
   logic [tdsd_pkg::SEG_W-1:0]     seg_ff, seg_in;
   logic [tdsd_pkg::CFG_W-1:0]     wait_ff, wait_in;
   logic                           init_ff, init_in;
   logic [tdsd_pkg::PATTERN_W-1:0] shown_ff, shown_in;

   // output register
   logic                           rsp_valid_ff;
   logic [tdsd_pkg::SEG_W-1:0]     rsp_mux_address_ff, rsp_mux_address_in;
   logic                           rsp_digit_select_ff, rsp_digit_select_in;
   logic                           rsp_showing_ff, rsp_showing_in;
   logic                           rsp_update_dropped_ff, rsp_update_dropped_in;

   logic advance, tick_go, value_go, push, pop, dropped;
   logic try_d1, after_d1, go_frame;

   logic [tdsd_pkg::PATTERN_W-1:0] head_data;
   logic [tdsd_pkg::PATTERN_W-1:0] frame_shown;
   logic                           frame_init;
   logic [7:0]                     cur_pat;
   logic [3:0]                     seg_from;
   tdsd_pkg::queue_status_type     qstat;
   tdsd_pkg::search_type           hit_cur, hit_d1, hit_f0, hit_f1;

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign tick_go   = advance && (in_op_ff == tdsd_pkg::OP_TICK);
   assign value_go  = advance && (in_op_ff == tdsd_pkg::OP_VALUE);
   assign push      = value_go && !qstat.full;
   assign dropped   = value_go && qstat.full;

   tdsd_update_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (tdsd_pkg::encode(in_value_ff, in_dot_ff)),
      .pop       (pop),
      .head_data (head_data),
      .status    (qstat)
   );

   assign dwell_eff = (dwell_ff == '0) ? tdsd_pkg::WAIT_ONE : dwell_ff;
   assign idle_eff  = (idle_poll_ff == '0) ? tdsd_pkg::WAIT_ONE : idle_poll_ff;

   assign cur_pat     = digit_ff ? shown_ff[15:8] : shown_ff[7:0];
   assign seg_from    = {1'b0, seg_ff} + 4'd1;
   assign hit_cur     = tdsd_pkg::search(cur_pat, seg_from);
   assign hit_d1      = tdsd_pkg::search(shown_ff[15:8], 4'd0);
   assign frame_shown = qstat.not_empty ? head_data : shown_ff;
   assign frame_init  = init_ff || qstat.not_empty;
   assign hit_f0      = tdsd_pkg::search(frame_shown[7:0], 4'd0);
   assign hit_f1      = tdsd_pkg::search(frame_shown[15:8], 4'd0);

   // next state of the scan
   always_comb begin
      phase_in = phase_ff;
      digit_in = digit_ff;
      seg_in   = seg_ff;
      wait_in  = wait_ff;
      init_in  = init_ff;
      shown_in = shown_ff;
      pop      = 1'b0;
      try_d1   = 1'b0;
      after_d1 = 1'b0;
      go_frame = 1'b0;
      if (tick_go) begin
         if (wait_ff > tdsd_pkg::WAIT_ONE) begin
            wait_in = wait_ff - tdsd_pkg::WAIT_ONE;
         end else begin
            unique case (phase_ff)
               tdsd_pkg::PH_SEG: begin
                  if (hit_cur.found) begin
                     seg_in  = hit_cur.seg;
                     wait_in = dwell_eff;
                  end else if (digit_gap_ff != '0) begin
                     phase_in = tdsd_pkg::PH_DGAP;
                     wait_in  = digit_gap_ff;
                  end else if (!digit_ff) begin
                     try_d1 = 1'b1;
                  end else begin
                     after_d1 = 1'b1;
                  end
               end
               tdsd_pkg::PH_DGAP: begin
                  if (!digit_ff) begin
                     try_d1 = 1'b1;
                  end else begin
                     after_d1 = 1'b1;
                  end
               end
               default: begin
                  go_frame = 1'b1;
               end
            endcase

            if (try_d1) begin
               digit_in = 1'b1;
               if (hit_d1.found) begin
                  phase_in = tdsd_pkg::PH_SEG;
                  seg_in   = hit_d1.seg;
                  wait_in  = dwell_eff;
               end else if (digit_gap_ff != '0) begin
                  phase_in = tdsd_pkg::PH_DGAP;
                  wait_in  = digit_gap_ff;
               end else begin
                  after_d1 = 1'b1;
               end
            end

            if (after_d1) begin
               if (frame_gap_ff != '0) begin
                  phase_in = tdsd_pkg::PH_FGAP;
                  wait_in  = frame_gap_ff;
               end else begin
                  go_frame = 1'b1;
               end
            end

            if (go_frame) begin
               pop = qstat.not_empty;
               if (!frame_init) begin
                  phase_in = tdsd_pkg::PH_IDLE;
                  wait_in  = idle_eff;
               end else begin
                  init_in  = 1'b1;
                  shown_in = frame_shown;
                  digit_in = 1'b0;
                  if (hit_f0.found) begin
                     phase_in = tdsd_pkg::PH_SEG;
                     seg_in   = hit_f0.seg;
                     wait_in  = dwell_eff;
                  end else if (digit_gap_ff != '0) begin
                     phase_in = tdsd_pkg::PH_DGAP;
                     wait_in  = digit_gap_ff;
                  end else begin
                     digit_in = 1'b1;
                     if (hit_f1.found) begin
                        phase_in = tdsd_pkg::PH_SEG;
                        seg_in   = hit_f1.seg;
                        wait_in  = dwell_eff;
                     end else if (digit_gap_ff != '0) begin
                        phase_in = tdsd_pkg::PH_DGAP;
                        wait_in  = digit_gap_ff;
                     end else if (frame_gap_ff != '0) begin
                        phase_in = tdsd_pkg::PH_FGAP;
                        wait_in  = frame_gap_ff;
                     end else begin
                        // empty frame: wait one tick
                        phase_in = tdsd_pkg::PH_FGAP;
                        wait_in  = tdsd_pkg::WAIT_ONE;
                     end
                  end
               end
            end
         end
      end
   end

   // result word: pins after the item
   always_comb begin
      rsp_mux_address_in    = seg_in;
      rsp_digit_select_in   = digit_in;
      rsp_showing_in        = init_in;
      rsp_update_dropped_in = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff     <= tdsd_pkg::DWELL_RESET;
         digit_gap_ff <= tdsd_pkg::DIGIT_GAP_RESET;
         frame_gap_ff <= tdsd_pkg::FRAME_GAP_RESET;
         idle_poll_ff <= tdsd_pkg::IDLE_POLL_RESET;
      end else if (csr_write_enable) begin
         unique case (tdsd_pkg::csr_index_type'(csr_index))
            tdsd_pkg::CSR_SEGMENT_DWELL: dwell_ff     <= csr_wdata;
            tdsd_pkg::CSR_DIGIT_GAP:     digit_gap_ff <= csr_wdata;
            tdsd_pkg::CSR_FRAME_GAP:     frame_gap_ff <= csr_wdata;
            tdsd_pkg::CSR_IDLE_POLL:     idle_poll_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_operation;
         in_value_ff <= req_value;
         in_dot_ff   <= req_dot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tdsd_pkg::PH_IDLE;
         digit_ff <= 1'b0;
         seg_ff   <= '0;
         wait_ff  <= tdsd_pkg::IDLE_POLL_RESET;
         init_ff  <= 1'b0;
         shown_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
         seg_ff   <= seg_in;
         wait_ff  <= wait_in;
         init_ff  <= init_in;
         shown_ff <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mux_address_ff    <= rsp_mux_address_in;
         rsp_digit_select_ff   <= rsp_digit_select_in;
         rsp_showing_ff        <= rsp_showing_in;
         rsp_update_dropped_ff <= rsp_update_dropped_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mux_address    = rsp_mux_address_ff;
   assign rsp_digit_select   = rsp_digit_select_ff;
   assign rsp_showing        = rsp_showing_ff;
   assign rsp_update_dropped = rsp_update_dropped_ff;

   // every word that leaves the input register lands in the output register
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("output word missing after advance");

   // once showing, the display never goes back to idle poll
   assert property (@(posedge clock) disable iff (reset) init_ff |=> init_ff)
      else $error("showing flag fell");

   // a loaded wait is never zero
   assert property (@(posedge clock) disable iff (reset) wait_ff != '0)
      else $error("wait counter at zero");

   // an addressed segment is lit in the shown pattern
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == tdsd_pkg::PH_SEG |-> shown_ff[{digit_ff, seg_ff}])
      else $error("addressed segment not lit");

   // a value word that finds the queue full is flagged
   assert property (@(posedge clock) disable iff (reset)
      value_go && qstat.full |=> rsp_update_dropped_ff)
      else $error("dropped update not flagged");

endmodule

`default_nettype wire
